### rtl/i2crw_pkg.sv
// ----------------------------------------------------------------------------
// I2C register write master - shared package
// Field widths, register indexes, reset values and the word types that move
// between the request path, the phase machine and the result buffer.
// ----------------------------------------------------------------------------
package i2crw_pkg;

    localparam int BYTE_W        = 8;
    localparam int HOLD_W        = 8;
    localparam int NACK_W        = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int BITS_PER_BYTE = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD = CFG_IDX_W'(1);

    // configuration reset values
    localparam logic [HOLD_W-1:0] LONG_HOLD_RST  = HOLD_W'(10);
    localparam logic [HOLD_W-1:0] SHORT_HOLD_RST = HOLD_W'(2);

    // request type codes
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] device_byte;
        logic [BYTE_W-1:0] register_addr;
        logic [BYTE_W-1:0] write_data;
        logic              sda_sample;
    } t_req;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [NACK_W-1:0] nack_flags;
        logic              rejected;
    } t_result;

endpackage

### rtl/i2crw_if.sv
// ----------------------------------------------------------------------------
// I2C register write master - channel interfaces
// Request, result and configuration channels, each with valid/ready.
// ----------------------------------------------------------------------------

// request channel: tick or write command
interface i2crw_req_if;
    import i2crw_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] device_byte;
    logic [BYTE_W-1:0] register_addr;
    logic [BYTE_W-1:0] write_data;
    logic              sda_sample;

    modport source (
        output valid, req_type, device_byte, register_addr, write_data, sda_sample,
        input  ready
    );
    modport sink (
        input  valid, req_type, device_byte, register_addr, write_data, sda_sample,
        output ready
    );
endinterface

// result channel: one word per request
interface i2crw_res_if;
    import i2crw_pkg::*;

    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [NACK_W-1:0] nack_flags;
    logic              rejected;

    modport source (
        output valid, scl_level, sda_level, busy_res, done_res, nack_flags, rejected,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, busy_res, done_res, nack_flags, rejected,
        output ready
    );
endinterface

// configuration write channel
interface i2crw_cfg_if;
    import i2crw_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [HOLD_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/i2crw_core.sv
// ----------------------------------------------------------------------------
// I2C register write master - phase machine
// Steps start, three bytes with acknowledges, and stop, one tick per word.
// The result word for the accepted request is formed combinationally.
// ----------------------------------------------------------------------------
module i2crw_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  i2crw_pkg::t_req                   i_req,
    input  logic [i2crw_pkg::HOLD_W-1:0]      i_long_hold,
    input  logic [i2crw_pkg::HOLD_W-1:0]      i_short_hold,
    output i2crw_pkg::t_result                o_result
);
    import i2crw_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_HIGH,
        PH_ST_LOW,
        PH_BIT_LOW,
        PH_BIT_DATA,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_REL,
        PH_ACK_HIGH,
        PH_SP_LOW,
        PH_SP_SCL,
        PH_SP_SDA
    } t_phase;

    // line drive codes: {scl, sda}
    localparam logic [1:0] DRV_NONE = 2'b00;
    localparam logic [1:0] DRV_SDA  = 2'b01;
    localparam logic [1:0] DRV_SCL  = 2'b10;
    localparam logic [1:0] DRV_BOTH = 2'b11;

    localparam logic [1:0] LAST_BYTE = 2'd3;

    t_phase            r_phase, n_phase;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [3:0]        r_bit, n_bit;
    logic [1:0]        r_byte, n_byte;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [BYTE_W-1:0] r_pend [2];
    logic [BYTE_W-1:0] n_pend [2];
    logic [NACK_W-1:0] r_nack, n_nack;
    logic [1:0]        r_drive, n_drive;

    logic [HOLD_W-1:0] hold_sel;
    logic [HOLD_W:0]   hold_eff;
    logic [HOLD_W:0]   hold_inc;
    logic              expire;
    logic [3:0]        bit_inc;
    logic [1:0]        byte_inc;
    logic              sda_keep;
    logic              done;
    logic              rej;

    // hold time of the current phase, zero counts as one tick
    always_comb begin
        hold_sel = i_short_hold;
        case (r_phase)
            PH_ST_HIGH, PH_ST_LOW, PH_SP_LOW, PH_SP_SCL, PH_SP_SDA: hold_sel = i_long_hold;
            default:                                                hold_sel = i_short_hold;
        endcase
    end

    assign hold_eff = (hold_sel == '0) ? (HOLD_W+1)'(1) : {1'b0, hold_sel};
    assign hold_inc = {1'b0, r_hold} + (HOLD_W+1)'(1);
    assign expire   = (hold_inc >= hold_eff);
    assign bit_inc  = r_bit + 4'd1;
    assign byte_inc = r_byte + 2'd1;
    assign sda_keep = r_drive[0];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hold  = r_hold;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_pend  = r_pend;
        n_nack  = r_nack;
        n_drive = r_drive;
        done    = 1'b0;
        rej     = 1'b0;

        if (i_req.req_type == REQ_WRITE) begin
            if (r_phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                n_shift   = i_req.device_byte;
                n_pend[0] = i_req.register_addr;
                n_pend[1] = i_req.write_data;
                n_bit     = '0;
                n_byte    = '0;
                n_nack    = '0;
                n_phase   = PH_ST_HIGH;
                n_hold    = '0;
                n_drive   = DRV_BOTH;
            end
        end else if (r_phase != PH_IDLE) begin
            if (expire) begin
                n_hold = '0;
                case (r_phase)
                    PH_ST_HIGH: begin
                        n_phase = PH_ST_LOW;
                        n_drive = DRV_SCL;
                    end
                    PH_ST_LOW: begin
                        n_phase = PH_BIT_LOW;
                        n_drive = DRV_NONE;
                    end
                    PH_BIT_LOW: begin
                        n_phase = PH_BIT_DATA;
                        n_drive = {1'b0, r_shift[BYTE_W-1]};
                    end
                    PH_BIT_DATA: begin
                        n_phase = PH_BIT_HIGH;
                        n_drive = {1'b1, sda_keep};
                    end
                    PH_BIT_HIGH: begin
                        n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                        n_bit   = bit_inc;
                        n_drive = {1'b0, sda_keep};
                        n_phase = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_BIT_LOW;
                    end
                    PH_ACK_LOW: begin
                        n_phase = PH_ACK_REL;
                        n_drive = DRV_SDA;
                    end
                    PH_ACK_REL: begin
                        // sample acknowledge at the end of the release phase
                        if (i_req.sda_sample && (r_byte != LAST_BYTE)) begin
                            n_nack = r_nack | (NACK_W'(1) << r_byte);
                        end
                        n_phase = PH_ACK_HIGH;
                        n_drive = DRV_BOTH;
                    end
                    PH_ACK_HIGH: begin
                        n_byte = byte_inc;
                        if (byte_inc == 2'd1 || byte_inc == 2'd2) begin
                            n_shift = (byte_inc == 2'd1) ? r_pend[0] : r_pend[1];
                            n_bit   = '0;
                            n_phase = PH_BIT_LOW;
                            n_drive = DRV_SDA;
                        end else begin
                            n_phase = PH_SP_LOW;
                            n_drive = DRV_NONE;
                        end
                    end
                    PH_SP_LOW: begin
                        n_phase = PH_SP_SCL;
                        n_drive = DRV_SCL;
                    end
                    PH_SP_SCL: begin
                        n_phase = PH_SP_SDA;
                        n_drive = DRV_BOTH;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_drive = DRV_BOTH;
                        done    = 1'b1;
                    end
                endcase
            end else begin
                n_hold = hold_inc[HOLD_W-1:0];
            end
        end
    end

    // result word: drive of the phase this tick belongs to
    always_comb begin
        o_result.scl_level  = r_drive[1];
        o_result.sda_level  = r_drive[0];
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = done;
        o_result.nack_flags = n_nack;
        o_result.rejected   = rej;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hold  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_nack  <= '0;
            r_drive <= DRV_BOTH;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_nack  <= n_nack;
            r_drive <= n_drive;
        end
    end

    // byte payload, written by a command before use
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_shift <= n_shift;
            r_pend  <= n_pend;
        end
    end

endmodule

### rtl/i2crw_skid.sv
// ----------------------------------------------------------------------------
// I2C register write master - result buffer
// Output register plus one skid entry, so the request side keeps moving
// while a finished word waits for the receiver.
// ----------------------------------------------------------------------------
module i2crw_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2crw_pkg::t_result   i_data,
    output logic                 o_in_ready,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    output i2crw_pkg::t_result   o_data
);
    import i2crw_pkg::*;

    logic    r_head_vld;
    logic    r_skid_vld;
    t_result r_head;
    t_result r_skid;
    logic    pop;
    logic    head_free;

    assign pop        = r_head_vld && i_out_ready;
    assign head_free  = !r_head_vld || pop;
    assign o_in_ready = !r_skid_vld;
    assign o_valid    = r_head_vld;
    assign o_data     = r_head;

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (head_free) begin
            if (r_skid_vld) begin
                r_head_vld <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_head_vld <= i_push;
            end
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (head_free) begin
            if (r_skid_vld) begin
                r_head <= r_skid;
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

### rtl/i2c_register_write_master_unit.sv
// ----------------------------------------------------------------------------
// I2C register write master - top level
// Bit-level master that sends start, device byte, register byte, data byte
// and stop, stepped by microsecond tick words.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : one word per tick (req_type 0, with the sampled SDA level) or a
//            write command (req_type 1, with the three bytes). A command
//            while busy is dropped and flagged as rejected.
//   o_res  : exactly one word per request word, in order: SCL/SDA drive for
//            that tick, busy, done at the end of the stop, per-byte nack
//            flags, and the rejected flag.
//   i_cfg  : writes long_hold_ticks (index 0) and short_hold_ticks (index 1);
//            always ready; the user writes it only while the block is idle (the block does not check).
// Timing: one request word per clock while i_req.ready is high. The result
//   word is registered in the output register, or in the skid entry while
//   o_res is held; the phase machine updates in the same cycle from its state registers and the request.
// Stall: a one-entry skid behind the output register keeps i_req.ready high
//   for one more word while o_res is held; ready drops only when both are
//   full, and no word is lost.
// Reset: hold ticks return to 10 and 2, the machine goes idle with both
//   lines released high, and the result buffer empties.
// ----------------------------------------------------------------------------
module i2c_register_write_master_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2crw_req_if.sink   i_req,
    i2crw_res_if.source o_res,
    i2crw_cfg_if.sink   i_cfg
);
    import i2crw_pkg::*;

    logic [HOLD_W-1:0] r_long_hold;
    logic [HOLD_W-1:0] r_short_hold;
    t_req              req;
    t_result           core_res;
    t_result           out_res;
    logic              in_ready;
    logic              accept;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_hold  <= LONG_HOLD_RST;
            r_short_hold <= SHORT_HOLD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LONG_HOLD:  r_long_hold  <= i_cfg.data;
                REG_SHORT_HOLD: r_short_hold <= i_cfg.data;
                default:        ;
            endcase
        end
    end

    // request word
    always_comb begin
        req.req_type      = i_req.req_type;
        req.device_byte   = i_req.device_byte;
        req.register_addr = i_req.register_addr;
        req.write_data    = i_req.write_data;
        req.sda_sample    = i_req.sda_sample;
    end

    assign i_req.ready = in_ready;
    assign accept      = i_req.valid && in_ready;

    i2crw_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req        (req),
        .i_long_hold  (r_long_hold),
        .i_short_hold (r_short_hold),
        .o_result     (core_res)
    );

    i2crw_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (core_res),
        .o_in_ready  (in_ready),
        .o_valid     (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_data      (out_res)
    );

    // result word
    assign o_res.scl_level  = out_res.scl_level;
    assign o_res.sda_level  = out_res.sda_level;
    assign o_res.busy_res   = out_res.busy_res;
    assign o_res.done_res   = out_res.done_res;
    assign o_res.nack_flags = out_res.nack_flags;
    assign o_res.rejected   = out_res.rejected;

endmodule

### rtl/i2crw_checker.sv
// ----------------------------------------------------------------------------
// I2C register write master - port checker
// Checks on the request and result channels as seen at the top level ports.
// ----------------------------------------------------------------------------
module i2crw_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_ready,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic                          i_res_scl,
    input  logic                          i_res_sda,
    input  logic                          i_res_busy,
    input  logic                          i_res_done,
    input  logic [i2crw_pkg::NACK_W-1:0]  i_res_nack,
    input  logic                          i_res_rejected
);
    import i2crw_pkg::*;

    // end of stop: machine idle with both lines released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_done |-> !i_res_busy && i_res_scl && i_res_sda)
        else $error("done word not idle with lines high");

    // a command is only turned away while a transfer runs
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_rejected |-> i_res_busy && !i_res_done)
        else $error("rejected word outside a transfer");

    // request side backs up only behind a waiting result word
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> i_res_valid)
        else $error("request stalled with empty output");

    // reset empties the result buffer
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable({i_res_scl, i_res_sda, i_res_busy, i_res_done,
                        i_res_nack, i_res_rejected}))
        else $error("stalled result word changed");

endmodule

bind i2c_register_write_master_unit i2crw_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_scl      (o_res.scl_level),
    .i_res_sda      (o_res.sda_level),
    .i_res_busy     (o_res.busy_res),
    .i_res_done     (o_res.done_res),
    .i_res_nack     (o_res.nack_flags),
    .i_res_rejected (o_res.rejected)
);

### tb/sv/tb_i2c_register_write_master_unit.sv
// ----------------------------------------------------------------------------
// I2C register write master - testbench
// Sends tick and write-command words into the block and checks every result
// word against a cycle-free model of the start/byte/ack/stop phase machine.
// Directed transactions come first: reset hold values, zero holds, all-nack
// and all-ack byte runs, and commands that land while busy. Random
// transactions follow at low and high hold settings, under three idling
// patterns, with one long result stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_i2c_register_write_master_unit;
    import i2crw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STALL_CYCLES   = 300;

    // line drive encoding: bit 1 SCL, bit 0 SDA, 1 = released high
    localparam logic [1:0] LINES_LOW  = 2'b00;
    localparam logic [1:0] LINE_SDA   = 2'b01;
    localparam logic [1:0] LINE_SCL   = 2'b10;
    localparam logic [1:0] LINES_HIGH = 2'b11;

    typedef enum logic [3:0] {
        BUS_IDLE, START_HIGH, START_LOW, BIT_LOW, BIT_DATA, BIT_HIGH,
        ACK_LOW, ACK_RELEASE, ACK_HIGH, STOP_LOW, STOP_SCL, STOP_SDA
    } t_bus_phase;

    // what the slave side drives on SDA through a transaction
    typedef enum int {ACK_ALL, NACK_ALL, ACK_RANDOM} t_ack_plan;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2crw_req_if req_ch ();
    i2crw_res_if res_ch ();
    i2crw_cfg_if cfg_ch ();

    i2c_register_write_master_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10;
        i_clk = ~i_clk;
    end

    // model state and hold settings
    logic [HOLD_W-1:0]  long_hold;
    logic [HOLD_W-1:0]  short_hold;
    t_bus_phase         bus_phase;
    logic [HOLD_W-1:0]  tick_cnt;
    logic [3:0]         bit_cnt;
    logic [1:0]         byte_cnt;
    logic [BYTE_W-1:0]  shifter;
    logic [BYTE_W-1:0]  staged [2];
    logic [NACK_W-1:0]  nack_bits;
    logic [1:0]         lines;

    t_req    pending_reqs [$];
    t_result expected_words [$];

    int send_idle_pct;
    int recv_idle_pct;
    int recv_stall_left;
    int mismatches;
    int quiet_cycles = 0;

    // a hold of zero behaves as one tick
    function automatic logic [HOLD_W-1:0] hold_of(t_bus_phase ph);
        logic [HOLD_W-1:0] h;
        if (ph == START_HIGH || ph == START_LOW || ph >= STOP_LOW)
            h = long_hold;
        else
            h = short_hold;
        return (h == '0) ? HOLD_W'(1) : h;
    endfunction

    function automatic void enter_phase(t_bus_phase ph, logic [1:0] drv);
        bus_phase = ph;
        tick_cnt  = '0;
        lines     = drv;
    endfunction

    // apply one request word to the model, return the word it produces
    function automatic t_result advance_bus(t_req rq);
        t_result    r;
        logic [1:0] drv_now;
        logic       sda_keep;
        logic       data_bit;
        logic       done_now;
        logic       rej_now;
        done_now = 1'b0;
        rej_now  = 1'b0;
        if (rq.req_type == REQ_WRITE) begin
            if (bus_phase != BUS_IDLE) begin
                rej_now = 1'b1;
            end else begin
                shifter   = rq.device_byte;
                staged[0] = rq.register_addr;
                staged[1] = rq.write_data;
                bit_cnt   = '0;
                byte_cnt  = '0;
                nack_bits = '0;
                enter_phase(START_HIGH, LINES_HIGH);
            end
            drv_now = lines;
        end else begin
            drv_now = lines;
            if (bus_phase != BUS_IDLE) begin
                sda_keep = lines[0];
                data_bit = shifter[7];
                if ({1'b0, tick_cnt} + 9'd1 >= {1'b0, hold_of(bus_phase)}) begin
                    case (bus_phase)
                        START_HIGH: enter_phase(START_LOW, LINE_SCL);
                        START_LOW:  enter_phase(BIT_LOW, LINES_LOW);
                        BIT_LOW:    enter_phase(BIT_DATA, data_bit ? LINE_SDA : LINES_LOW);
                        BIT_DATA:   enter_phase(BIT_HIGH, LINE_SCL | {1'b0, sda_keep});
                        BIT_HIGH: begin
                            shifter = shifter << 1;
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= 4'd8)
                                enter_phase(ACK_LOW, {1'b0, sda_keep});
                            else
                                enter_phase(BIT_LOW, {1'b0, sda_keep});
                        end
                        ACK_LOW:    enter_phase(ACK_RELEASE, LINE_SDA);
                        ACK_RELEASE: begin
                            // SDA still high at the end of release: no ack
                            if (rq.sda_sample && byte_cnt != 2'd3)
                                nack_bits = nack_bits | (3'b001 << byte_cnt);
                            enter_phase(ACK_HIGH, LINES_HIGH);
                        end
                        ACK_HIGH: begin
                            byte_cnt = byte_cnt + 2'd1;
                            if (byte_cnt == 2'd1 || byte_cnt == 2'd2) begin
                                shifter = staged[1'(byte_cnt - 2'd1)];
                                bit_cnt = '0;
                                enter_phase(BIT_LOW, LINE_SDA);
                            end else begin
                                enter_phase(STOP_LOW, LINES_LOW);
                            end
                        end
                        STOP_LOW:   enter_phase(STOP_SCL, LINE_SCL);
                        STOP_SCL:   enter_phase(STOP_SDA, LINES_HIGH);
                        default: begin
                            enter_phase(BUS_IDLE, LINES_HIGH);
                            done_now = 1'b1;
                        end
                    endcase
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                end
            end
        end
        r.scl_level  = drv_now[1];
        r.sda_level  = drv_now[0];
        r.busy_res   = (bus_phase != BUS_IDLE);
        r.done_res   = done_now;
        r.nack_flags = nack_bits;
        r.rejected   = rej_now;
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_req command_word(logic [BYTE_W-1:0] dev, logic [BYTE_W-1:0] reg_a,
                                          logic [BYTE_W-1:0] dat);
        t_req w;
        w.req_type      = REQ_WRITE;
        w.device_byte   = dev;
        w.register_addr = reg_a;
        w.write_data    = dat;
        w.sda_sample    = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_req tick_word(logic sda);
        t_req w;
        w.req_type      = REQ_TICK;
        w.device_byte   = BYTE_W'($urandom_range(0, 255));
        w.register_addr = BYTE_W'($urandom_range(0, 255));
        w.write_data    = BYTE_W'($urandom_range(0, 255));
        w.sda_sample    = sda;
        return w;
    endfunction

    // queue one command and exactly the ticks it needs to finish, with
    // stray commands scattered while busy
    task automatic push_write(input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] reg_a,
                              input logic [BYTE_W-1:0] dat, input t_ack_plan plan,
                              input bit rej_first);
        int n_ticks;
        int l_eff;
        int s_eff;
        @(negedge i_clk);
        l_eff   = (long_hold == '0) ? 1 : int'(long_hold);
        s_eff   = (short_hold == '0) ? 1 : int'(short_hold);
        n_ticks = 5 * l_eff + 27 * BITS_PER_BYTE / 8 * 3 * s_eff;
        pending_reqs.push_back(command_word(dev, reg_a, dat));
        if (rej_first)
            pending_reqs.push_back(command_word(pick_byte(), pick_byte(), pick_byte()));
        for (int k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 39) == 0)
                pending_reqs.push_back(command_word(pick_byte(), pick_byte(), pick_byte()));
            case (plan)
                ACK_ALL:  pending_reqs.push_back(tick_word(1'b0));
                NACK_ALL: pending_reqs.push_back(tick_word(1'b1));
                default:  pending_reqs.push_back(tick_word(1'($urandom_range(0, 1))));
            endcase
        end
    endtask

    task automatic push_idle_ticks(input int n);
        @(negedge i_clk);
        repeat (n) pending_reqs.push_back(tick_word(1'($urandom_range(0, 1))));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_words.size() != 0 || req_ch.valid)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_LONG_HOLD:  long_hold  = val;
            REG_SHORT_HOLD: short_hold = val;
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [2:0] want,
                                 input logic [2:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // request driver: present the oldest pending word, hold it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                expected_words.push_back(advance_bus(pending_reqs.pop_front()));
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_ch.valid         <= 1'b1;
                    req_ch.req_type      <= pending_reqs[0].req_type;
                    req_ch.device_byte   <= pending_reqs[0].device_byte;
                    req_ch.register_addr <= pending_reqs[0].register_addr;
                    req_ch.write_data    <= pending_reqs[0].write_data;
                    req_ch.sda_sample    <= pending_reqs[0].sda_sample;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: check each taken word, throttle ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected: scl %0b sda %0b busy %0b",
                             $time, res_ch.scl_level, res_ch.sda_level, res_ch.busy_res);
                    mismatches++;
                end else begin
                    compare_field("scl_level", expected_words[0].scl_level, res_ch.scl_level);
                    compare_field("sda_level", expected_words[0].sda_level, res_ch.sda_level);
                    compare_field("busy_res", expected_words[0].busy_res, res_ch.busy_res);
                    compare_field("done_res", expected_words[0].done_res, res_ch.done_res);
                    compare_field("nack_flags", expected_words[0].nack_flags,
                                  res_ch.nack_flags);
                    compare_field("rejected", expected_words[0].rejected, res_ch.rejected);
                    void'(expected_words.pop_front());
                end
            end
            if (recv_stall_left > 0) begin
                recv_stall_left = recv_stall_left - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: too long without any word moving on any channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_TICK;
        req_ch.device_byte   = '0;
        req_ch.register_addr = '0;
        req_ch.write_data    = '0;
        req_ch.sda_sample    = 1'b0;
        res_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_LONG_HOLD;
        cfg_ch.data          = '0;

        long_hold  = LONG_HOLD_RST;
        short_hold = SHORT_HOLD_RST;
        bus_phase  = BUS_IDLE;
        tick_cnt   = '0;
        bit_cnt    = '0;
        byte_cnt   = '0;
        shifter    = '0;
        staged[0]  = '0;
        staged[1]  = '0;
        nack_bits  = '0;
        lines      = LINES_HIGH;

        mismatches      = 0;
        recv_stall_left = 0;
        send_idle_pct   = 28;
        recv_idle_pct   = 64;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset hold values: idle ticks, then all bytes nacked
        push_idle_ticks(3);
        push_write(8'hFF, 8'h00, 8'hFF, NACK_ALL, 1'b1);
        wait_drained();

        // zero holds act as one tick; all acked, then back to back
        write_reg(REG_LONG_HOLD, 8'd0);
        write_reg(REG_SHORT_HOLD, 8'd0);
        push_write(8'h00, 8'hFF, 8'h00, ACK_ALL, 1'b1);
        push_write(pick_byte(), pick_byte(), pick_byte(), ACK_RANDOM, 1'b0);
        wait_drained();

        // shortest holds: long result stall, then a drain pause
        write_reg(REG_LONG_HOLD, 8'd1);
        write_reg(REG_SHORT_HOLD, 8'd1);
        push_write(pick_byte(), pick_byte(), pick_byte(), ACK_RANDOM, 1'b0);
        push_idle_ticks($urandom_range(0, 3));
        push_write(pick_byte(), pick_byte(), pick_byte(), ACK_RANDOM, 1'b0);
        recv_stall_left = STALL_CYCLES;
        wait_drained();
        push_write(pick_byte(), pick_byte(), pick_byte(), ACK_RANDOM, 1'b0);
        push_idle_ticks($urandom_range(0, 3));
        wait_drained();

        // long start/stop hold, idling swapped
        send_idle_pct = 64;
        recv_idle_pct = 28;
        write_reg(REG_LONG_HOLD, 8'd24);
        write_reg(REG_SHORT_HOLD, 8'd1);
        push_write(pick_byte(), pick_byte(), pick_byte(), ACK_RANDOM, 1'b0);
        wait_drained();
        write_reg(REG_SHORT_HOLD, 8'd255);
        push_idle_ticks(16);
        wait_drained();

        // small random holds, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_LONG_HOLD, HOLD_W'($urandom_range(1, 6)));
        write_reg(REG_SHORT_HOLD, HOLD_W'($urandom_range(1, 3)));
        push_idle_ticks($urandom_range(0, 2));
        push_write(pick_byte(), pick_byte(), pick_byte(), ACK_RANDOM, 1'b0);
        push_idle_ticks($urandom_range(0, 3));
        wait_drained();

        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/i2crw_pkg.sv
rtl/i2crw_if.sv
rtl/i2crw_core.sv
rtl/i2crw_skid.sv
rtl/i2c_register_write_master_unit.sv
rtl/i2crw_checker.sv
tb/sv/tb_i2c_register_write_master_unit.sv
